>>> src/rgbhsl_pkg.sv
`timescale 1ns / 1ps
package rgbhsl_pkg;

    localparam int unsigned HslTop   = 255;
    localparam int unsigned HueGrey  = (HslTop * 2) / 3;
    localparam int unsigned HueSixth = HslTop / 6;
    localparam int unsigned HueThird = HslTop / 3;
    localparam int unsigned HslHalf  = HslTop / 2;
    localparam int unsigned QuoBits  = 8;
    localparam int unsigned NumLanes = 4;

    // lane order in the divider row
    localparam int unsigned LaneSat = 0;
    localparam int unsigned LaneDr  = 1;
    localparam int unsigned LaneDg  = 2;
    localparam int unsigned LaneDb  = 3;

    typedef enum logic [1:0] {
        DOM_RED   = 2'd0,
        DOM_GREEN = 2'd1,
        DOM_BLUE  = 2'd2
    } dom_t;

    typedef struct packed {
        logic [15:0] rem;
        logic [8:0]  den;
        logic [7:0]  quo;
    } div_lane_t;

    typedef struct packed {
        logic                      valid;
        logic                      grey;
        dom_t                      dom;
        logic [7:0]                light;
        div_lane_t [NumLanes-1:0]  lane;
    } cell_data_t;

endpackage

>>> src/rgbhsl_prep.sv
`timescale 1ns / 1ps
module rgbhsl_prep (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  logic                    in_valid,
    input  logic [7:0]              red,
    input  logic [7:0]              green,
    input  logic [7:0]              blue,
    output rgbhsl_pkg::cell_data_t  data_out
);
    import rgbhsl_pkg::*;

    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [8:0]  sum;
    logic [8:0]  sum_inc;
    logic [7:0]  light;
    logic [7:0]  spread;
    logic [8:0]  den;
    dom_t        dom;
    cell_data_t  data_next;
    cell_data_t  data_reg;

    function automatic logic [15:0] delta_num(input logic [7:0] top, input logic [7:0] ch,
                                              input logic [7:0] spr);
        logic [7:0] diff;
        diff = top - ch;
        delta_num = 16'(diff) * 16'(HueSixth) + 16'(spr >> 1);
    endfunction

    always_comb
    begin
        hi = red;
        lo = red;
        if (green > hi) hi = green;
        if (blue > hi)  hi = blue;
        if (green < lo) lo = green;
        if (blue < lo)  lo = blue;

        if (red == hi)
            dom = DOM_RED;
        else if (green == hi)
            dom = DOM_GREEN;
        else
            dom = DOM_BLUE;

        sum     = {1'b0, hi} + {1'b0, lo};
        sum_inc = sum + 9'd1;
        light   = sum_inc[8:1];
        spread  = hi - lo;
        den     = (light <= 8'(HslHalf)) ? sum : (9'd510 - sum);

        data_next.valid = in_valid;
        data_next.grey  = (hi == lo);
        data_next.dom   = dom;
        data_next.light = light;

        data_next.lane[LaneSat].rem = 16'(spread) * 16'(HslTop) + 16'(den >> 1);
        data_next.lane[LaneSat].den = den;
        data_next.lane[LaneSat].quo = '0;
        data_next.lane[LaneDr].rem  = delta_num(hi, red, spread);
        data_next.lane[LaneDr].den  = {1'b0, spread};
        data_next.lane[LaneDr].quo  = '0;
        data_next.lane[LaneDg].rem  = delta_num(hi, green, spread);
        data_next.lane[LaneDg].den  = {1'b0, spread};
        data_next.lane[LaneDg].quo  = '0;
        data_next.lane[LaneDb].rem  = delta_num(hi, blue, spread);
        data_next.lane[LaneDb].den  = {1'b0, spread};
        data_next.lane[LaneDb].quo  = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            data_reg <= '0;
        else if (advance)
            data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

>>> src/rgbhsl_div_cell.sv
`timescale 1ns / 1ps
module rgbhsl_div_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  logic [2:0]              bit_idx,
    input  rgbhsl_pkg::cell_data_t  data_in,
    output rgbhsl_pkg::cell_data_t  data_out
);
    import rgbhsl_pkg::*;

    cell_data_t  data_next;
    cell_data_t  data_reg;
    logic [16:0] trial [NumLanes];

    // one restoring quotient bit per lane
    always_comb
    begin
        data_next = data_in;
        for (int i = 0; i < NumLanes; i++)
        begin
            trial[i] = {8'b0, data_in.lane[i].den} << bit_idx;
            if ({1'b0, data_in.lane[i].rem} >= trial[i])
            begin
                data_next.lane[i].rem          = data_in.lane[i].rem - trial[i][15:0];
                data_next.lane[i].quo[bit_idx] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            data_reg <= '0;
        else if (advance)
            data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

>>> src/rgbhsl_post.sv
`timescale 1ns / 1ps
module rgbhsl_post (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  rgbhsl_pkg::cell_data_t  data_in,
    output logic                    valid,
    output logic [7:0]              hue,
    output logic [7:0]              saturation,
    output logic [7:0]              lightness
);
    import rgbhsl_pkg::*;

    logic signed [9:0] dr;
    logic signed [9:0] dg;
    logic signed [9:0] db;
    logic signed [9:0] h;
    logic [7:0]        hue_next;
    logic [7:0]        sat_next;
    logic              valid_reg;
    logic [7:0]        hue_reg;
    logic [7:0]        sat_reg;
    logic [7:0]        light_reg;

    always_comb
    begin
        dr = signed'({2'b0, data_in.lane[LaneDr].quo});
        dg = signed'({2'b0, data_in.lane[LaneDg].quo});
        db = signed'({2'b0, data_in.lane[LaneDb].quo});
        case (data_in.dom)
            DOM_RED:   h = db - dg;
            DOM_GREEN: h = 10'sd85 + dr - db;
            DOM_BLUE:  h = 10'sd170 + dg - dr;
            default:   h = '0;
        endcase
        if (h < 0)
            h = h + 10'sd255;
        if (h > 10'sd255)
            h = h - 10'sd255;

        if (data_in.grey)
        begin
            hue_next = 8'(HueGrey);
            sat_next = '0;
        end
        else
        begin
            hue_next = h[7:0];
            sat_next = data_in.lane[LaneSat].quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= data_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            light_reg <= data_in.light;
        end
    end

    assign valid      = valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign lightness  = light_reg;

endmodule

>>> src/rgb_to_hsl_converter.sv
`timescale 1ns / 1ps
// channel | direction | handshake          | fields
// input   | in        | in_valid/in_stall   | red, green, blue (8b each)
// output  | out       | out_valid/out_stall | hue, saturation, lightness (8b each)
//
// One pixel per clock unless stalled; pipeline of prep cell, eight divider cells,
// and output register. The divider row yields one quotient bit per cell.
// Reset clears all valid bits; the pipeline is empty afterwards.
// A stalled result freezes the whole row, and in_stall rises with it.
module rgb_to_hsl_converter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] hue,
    output logic [7:0] saturation,
    output logic [7:0] lightness
);
    import rgbhsl_pkg::*;

    logic       advance;
    cell_data_t row [QuoBits+1];

    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    rgbhsl_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (in_valid),
        .red      (red),
        .green    (green),
        .blue     (blue),
        .data_out (row[0])
    );

    for (genvar k = 0; k < QuoBits; k++)
    begin : g_cell
        rgbhsl_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .bit_idx  (3'(QuoBits - 1 - k)),
            .data_in  (row[k]),
            .data_out (row[k+1])
        );
    end

    rgbhsl_post u_post (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .data_in    (row[QuoBits]),
        .valid      (out_valid),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness)
    );

endmodule

>>> bench/rgb_to_hsl_converter_tb.sv
`timescale 1ns / 1ps
module rgb_to_hsl_converter_tb;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_t;

    typedef struct packed {
        logic [7:0] h;
        logic [7:0] s;
        logic [7:0] l;
    } hsl_t;

    localparam int CycleLimit = 400000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] lightness;

    pixel_t pixel_q[$];
    pixel_t sent_pixel_q[$];
    hsl_t   hsl_expected_q[$];
    int     mismatch_count;
    int     cycle_count;
    int     gap_left;
    int     hold_left;
    bit     hold_done;
    bit     all_sent;
    pixel_t cur_pixel;
    int     sent_count;
    logic   in_stall_seen;

    rgb_to_hsl_converter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic int unsigned rounded_delta(int unsigned top, int unsigned ch,
                                                  int unsigned spread);
        return ((top - ch) * rgbhsl_pkg::HueSixth + spread / 2) / spread;
    endfunction

    function automatic hsl_t rgb_to_hsl(pixel_t p);
        int unsigned hi;
        int unsigned lo;
        int unsigned sum;
        int unsigned spread;
        int unsigned den;
        int unsigned dr;
        int unsigned dg;
        int unsigned db;
        int          h;
        hsl_t        res;
        hi = p.r;
        lo = p.r;
        if (p.g > hi) hi = p.g;
        if (p.b > hi) hi = p.b;
        if (p.g < lo) lo = p.g;
        if (p.b < lo) lo = p.b;
        sum = hi + lo;
        res.l = 8'((sum * 255 + 255) / 510);
        if (hi == lo)
        begin
            res.s = 8'd0;
            res.h = 8'(rgbhsl_pkg::HueGrey);
        end
        else
        begin
            spread = hi - lo;
            den = (res.l <= rgbhsl_pkg::HslHalf) ? sum : 510 - sum;
            res.s = 8'((spread * 255 + den / 2) / den);
            dr = rounded_delta(hi, p.r, spread);
            dg = rounded_delta(hi, p.g, spread);
            db = rounded_delta(hi, p.b, spread);
            if (p.r == hi)
                h = int'(db) - int'(dg);
            else if (p.g == hi)
                h = int'(rgbhsl_pkg::HueThird) + int'(dr) - int'(db);
            else
                h = int'(rgbhsl_pkg::HueGrey) + int'(dg) - int'(dr);
            if (h < 0) h += 255;
            if (h > 255) h -= 255;
            res.h = 8'(h);
        end
        return res;
    endfunction

    function automatic int random_gap();
        if ($urandom_range(0, 3) != 0) return 0;
        if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic report_mismatch(string field, int got, int want, pixel_t p);
        $display("mismatch %s: got %0d want %0d (rgb %0d %0d %0d)",
                 field, got, want, p.r, p.g, p.b);
        mismatch_count++;
    endtask

    task automatic add_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        pixel_q.push_back({r, g, b});
    endtask

    function automatic logic [7:0] random_level();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 3));
            1: return 8'($urandom_range(252, 255));
            default: return 8'($urandom);
        endcase
    endfunction

    // stimulus
    initial
    begin
        pixel_t p;
        add_pixel(8'd0, 8'd0, 8'd0);
        add_pixel(8'd255, 8'd255, 8'd255);
        add_pixel(8'd128, 8'd128, 8'd128);
        add_pixel(8'd255, 8'd0, 8'd0);
        add_pixel(8'd0, 8'd255, 8'd0);
        add_pixel(8'd0, 8'd0, 8'd255);
        add_pixel(8'd255, 8'd255, 8'd0);
        add_pixel(8'd0, 8'd255, 8'd255);
        add_pixel(8'd255, 8'd0, 8'd255);
        add_pixel(8'd200, 8'd200, 8'd10);
        add_pixel(8'd10, 8'd200, 8'd200);
        add_pixel(8'd255, 8'd0, 8'd1);
        add_pixel(8'd200, 8'd10, 8'd100);
        add_pixel(8'd127, 8'd128, 8'd128);
        add_pixel(8'd128, 8'd127, 8'd127);
        add_pixel(8'd1, 8'd0, 8'd0);
        add_pixel(8'd255, 8'd254, 8'd255);
        add_pixel(8'd170, 8'd85, 8'd170);
        add_pixel(8'd85, 8'd170, 8'd255);
        add_pixel(8'd254, 8'd1, 8'd0);
        for (int i = 0; i < 1530; i++)
        begin
            p = {random_level(), random_level(), random_level()};
            case ($urandom_range(0, 9))
                0: p.g = p.r;
                1: p.b = p.g;
                2:
                begin
                    p.g = p.r;
                    p.b = p.r;
                end
                default: ;
            endcase
            pixel_q.push_back(p);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // driver
    initial
    begin
        in_valid = 1'b0;
        {red, green, blue} = '0;
        gap_left = 0;
        sent_count = 0;
        all_sent = 1'b0;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall_seen)
            begin
                sent_count++;
                if (sent_count == 700 && pixel_q.size() != 0)
                    gap_left = -1; // drain before going on
                else
                    gap_left = random_gap();
            end
            if (in_valid && in_stall_seen)
            begin
                // holding payload
            end
            else if (gap_left == -1 && hsl_expected_q.size() != 0)
            begin
                in_valid <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pixel_q.size() != 0)
            begin
                gap_left = 0;
                cur_pixel = pixel_q.pop_front();
                red <= cur_pixel.r;
                green <= cur_pixel.g;
                blue <= cur_pixel.b;
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
                all_sent = 1'b1;
            end
        end
    end

    // acceptance seen at the rising edge
    initial in_stall_seen = 1'b0;
    always @(posedge clk)
    begin
        in_stall_seen <= in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            hsl_expected_q.push_back(rgb_to_hsl({red, green, blue}));
            sent_pixel_q.push_back({red, green, blue});
        end
    end

    // receiver stall, with one long hold while the sender keeps offering
    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
    end

    always @(negedge clk)
    begin
        if (!hold_done && sent_count >= 300)
        begin
            hold_done = 1'b1;
            hold_left = 60;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (cycle_count % 400 < 100)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 3) == 0) ||
                         ($urandom_range(0, 40) == 0 && random_gap() > 0);
    end

    // monitor
    always @(posedge clk)
    begin
        hsl_t   want;
        pixel_t src;
        if (rst_n && out_valid && !out_stall)
        begin
            if (hsl_expected_q.size() == 0)
            begin
                $display("unexpected transaction: hsl %0d %0d %0d",
                         hue, saturation, lightness);
                mismatch_count++;
            end
            else
            begin
                want = hsl_expected_q.pop_front();
                src = sent_pixel_q.pop_front();
                if (hue != want.h)
                    report_mismatch("hue", int'(hue), int'(want.h), src);
                if (saturation != want.s)
                    report_mismatch("saturation", int'(saturation), int'(want.s), src);
                if (lightness != want.l)
                    report_mismatch("lightness", int'(lightness), int'(want.l), src);
            end
        end
    end

    initial
    begin
        mismatch_count = 0;
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("timeout");
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        wait (all_sent);
        wait (hsl_expected_q.size() == 0);
        repeat (30) @(posedge clk);
        if (mismatch_count == 0 && hsl_expected_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
